### rtl/desa_pkg.sv
// Shared constants, codes and lane control structures for the dual encoder
// speed averager. No dependencies; every other file imports this package.
package desa_pkg;

    localparam int WINDOW_DEPTH  = 8;
    localparam int FRACTION_BITS = 16;
    localparam int SCALE_FRAC    = 16;

    localparam int COUNT_W = 32;
    localparam int TICK_W  = 8;
    localparam int SCALE_W = 32;
    localparam int SPEED_W = 48;

    // one per-tick value, and the running sum over the window
    localparam int ENTRY_W = COUNT_W + FRACTION_BITS;
    localparam int SLOT_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W   = ENTRY_W + $clog2(WINDOW_DEPTH) + 1;

    // iterative divider: quotient bits retired per cycle
    localparam int DIV_STEPS = 2;
    localparam int DIV_W     = ((SUM_W + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
    localparam int DIV_ITER  = DIV_W / DIV_STEPS;
    localparam int DVS_W     = (TICK_W > FILL_W) ? TICK_W : FILL_W;

    // scale multiply, split into low and high partial products
    localparam int PROD_W = 2 * SCALE_W;
    localparam int Q_W    = PROD_W - SCALE_FRAC;

    localparam int CFG_DATA_W = SCALE_W;

    typedef enum logic [0:0] {
        CFG_LEFT_SCALE  = 1'b0,
        CFG_RIGHT_SCALE = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic              start;
        logic              release_lane;
        logic              restart;
        logic [TICK_W-1:0] tick_span;
    } lane_cmd_t;

    typedef struct packed {
        logic                      done;
        logic signed [SPEED_W-1:0] speed;
        logic signed [COUNT_W-1:0] raw_delta;
    } lane_status_t;

endpackage

### rtl/desa_sample_if.sv
// Measurement channel: valid/ready handshake plus one sample beat.
// Depends on desa_pkg for field widths.
interface desa_sample_if;
    import desa_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      restart;
    logic signed [COUNT_W-1:0] left_hall_count;
    logic signed [COUNT_W-1:0] right_hall_count;
    logic [TICK_W-1:0]         tick_span;

    modport source (
        output valid, restart, left_hall_count, right_hall_count, tick_span,
        input  ready
    );

    modport sink (
        input  valid, restart, left_hall_count, right_hall_count, tick_span,
        output ready
    );

endinterface

### rtl/desa_report_if.sv
// Result channel: valid/ready handshake plus one speed report beat.
// Depends on desa_pkg for field widths.
interface desa_report_if;
    import desa_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      updated;
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;
    logic signed [COUNT_W-1:0] left_raw_delta;
    logic signed [COUNT_W-1:0] right_raw_delta;
    logic [COUNT_W-1:0]        update_total;

    modport source (
        output valid, updated, left_speed, right_speed, left_raw_delta,
               right_raw_delta, update_total,
        input  ready
    );

    modport sink (
        input  valid, updated, left_speed, right_speed, left_raw_delta,
               right_raw_delta, update_total,
        output ready
    );

endinterface

### rtl/desa_div.sv
// Iterative unsigned restoring divider, DIV_STEPS quotient bits per cycle.
// Depends on desa_pkg for operand widths and the iteration count.
module desa_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [desa_pkg::DIV_W-1:0] dividend,
    input  logic [desa_pkg::DVS_W-1:0] divisor,
    output logic                       done,
    output logic [desa_pkg::DIV_W-1:0] quotient
);
    import desa_pkg::*;

    localparam int CNT_W = $clog2(DIV_ITER + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;

    logic [DVS_W-1:0] rem_w;
    logic [DIV_W-1:0] quo_w;
    logic [DVS_W:0]   trial;

    // retire DIV_STEPS quotient bits
    always_comb
    begin
        rem_w = rem_reg;
        quo_w = quo_reg;
        trial = '0;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            trial = {rem_w, quo_w[DIV_W-1]};
            quo_w = {quo_w[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial    = trial - {1'b0, dvs_reg};
                quo_w[0] = 1'b1;
            end
            rem_w = trial[DVS_W-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_ITER);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = rem_w;
            quo_next = quo_w;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/desa_lane.sv
// One wheel lane: wrapped delta, per-tick divide, ring window with running
// sum, window average divide, scale multiply and saturation. Uses desa_div.
module desa_lane (
    input  logic                              clk,
    input  logic                              rst_n,
    input  desa_pkg::lane_cmd_t               cmd,
    input  logic signed [desa_pkg::COUNT_W-1:0] count,
    input  logic signed [desa_pkg::SCALE_W-1:0] scale,
    output desa_pkg::lane_status_t            status
);
    import desa_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_TICK_DIV = 9'b000000010,
        ST_COMMIT   = 9'b000000100,
        ST_CHECK    = 9'b000001000,
        ST_AVG_DIV  = 9'b000010000,
        ST_MUL_LO   = 9'b000100000,
        ST_MUL_HI   = 9'b001000000,
        ST_SATURATE = 9'b010000000,
        ST_DONE     = 9'b100000000
    } lane_state_t;

    lane_state_t state_reg, state_next;

    logic [COUNT_W-1:0]        baseline_reg, baseline_next;
    logic [SLOT_W-1:0]         slot_reg, slot_next;
    logic [FILL_W-1:0]         fill_reg, fill_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [ENTRY_W-1:0] win_reg [WINDOW_DEPTH];

    logic signed [COUNT_W-1:0] raw_delta_reg, raw_delta_next;
    logic [COUNT_W-1:0]        count_reg, count_next;
    logic signed [SCALE_W-1:0] scale_reg, scale_next;
    logic                      delta_neg_reg, delta_neg_next;
    logic signed [ENTRY_W-1:0] tick_val_reg, tick_val_next;
    logic [SUM_W-1:0]          avg_reg, avg_next;
    logic [PROD_W-1:0]         prod_lo_reg, prod_lo_next;
    logic [PROD_W-1:0]         prod_hi_reg, prod_hi_next;
    logic signed [SPEED_W-1:0] speed_reg, speed_next;

    logic                      win_we;
    logic                      div_start;
    logic [DIV_W-1:0]          div_dividend;
    logic [DVS_W-1:0]          div_divisor;
    logic                      div_done;
    logic [DIV_W-1:0]          div_quotient;

    logic [COUNT_W-1:0]        delta;
    logic [COUNT_W-1:0]        delta_mag;
    logic [SUM_W-1:0]          sum_mag;
    logic [ENTRY_W-1:0]        tick_q;
    logic signed [ENTRY_W-1:0] old_entry;
    logic                      window_full;
    logic [SCALE_W-1:0]        scale_mag;
    logic [SCALE_W-1:0]        mul_a;
    logic [PROD_W-1:0]         mul_p;
    logic                      speed_neg;
    logic                      sat_hi;
    logic [Q_W:0]              q_sum;
    logic [SPEED_W-1:0]        lim;
    logic [SPEED_W-1:0]        q_mag;

    desa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign delta       = COUNT_W'(count) - baseline_reg;
    assign delta_mag   = delta[COUNT_W-1] ? COUNT_W'(0) - delta : delta;
    assign sum_mag     = sum_reg[SUM_W-1] ? SUM_W'(0) - SUM_W'(sum_reg) : SUM_W'(sum_reg);
    assign tick_q      = div_quotient[ENTRY_W-1:0];
    assign window_full = (fill_reg == FILL_W'(WINDOW_DEPTH));
    assign old_entry   = window_full ? win_reg[slot_reg] : '0;

    // one shared multiplier for both partial products
    assign scale_mag = scale_reg[SCALE_W-1] ? SCALE_W'(0) - SCALE_W'(scale_reg)
                                            : SCALE_W'(scale_reg);
    assign mul_a     = (state_reg == ST_MUL_HI) ? SCALE_W'(avg_reg[SUM_W-1:SCALE_W])
                                                : avg_reg[SCALE_W-1:0];
    assign mul_p     = PROD_W'(mul_a) * PROD_W'(scale_mag);

    // drop SCALE_FRAC bits, clamp to the signed speed range
    always_comb
    begin
        speed_neg = sum_reg[SUM_W-1] ^ scale_reg[SCALE_W-1];
        sat_hi    = |prod_hi_reg[PROD_W-1:SCALE_W];
        q_sum     = (Q_W+1)'({prod_hi_reg[SCALE_W-1:0], {(SCALE_W-SCALE_FRAC){1'b0}}})
                  + (Q_W+1)'(prod_lo_reg[PROD_W-1:SCALE_FRAC]);
        lim       = speed_neg ? {1'b1, {(SPEED_W-1){1'b0}}} : {1'b0, {(SPEED_W-1){1'b1}}};
        if (sat_hi || (q_sum > (Q_W+1)'(lim)))
        begin
            q_mag = lim;
        end
        else
        begin
            q_mag = q_sum[SPEED_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        baseline_next  = baseline_reg;
        slot_next      = slot_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        raw_delta_next = raw_delta_reg;
        count_next     = count_reg;
        scale_next     = scale_reg;
        delta_neg_next = delta_neg_reg;
        tick_val_next  = tick_val_reg;
        avg_next       = avg_reg;
        prod_lo_next   = prod_lo_reg;
        prod_hi_next   = prod_hi_reg;
        speed_next     = speed_reg;
        win_we         = 1'b0;
        div_start      = 1'b0;
        div_dividend   = '0;
        div_divisor    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    scale_next = scale;
                    count_next = COUNT_W'(count);
                    if (cmd.restart)
                    begin
                        baseline_next  = COUNT_W'(count);
                        sum_next       = '0;
                        fill_next      = '0;
                        slot_next      = '0;
                        raw_delta_next = '0;
                        speed_next     = '0;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        raw_delta_next = signed'(delta);
                        delta_neg_next = delta[COUNT_W-1];
                        if (cmd.tick_span == '0)
                        begin
                            state_next = ST_CHECK;
                        end
                        else
                        begin
                            div_start    = 1'b1;
                            div_dividend = DIV_W'({delta_mag, {FRACTION_BITS{1'b0}}});
                            div_divisor  = DVS_W'(cmd.tick_span);
                            state_next   = ST_TICK_DIV;
                        end
                    end
                end
            end
            ST_TICK_DIV:
            begin
                if (div_done)
                begin
                    tick_val_next = signed'(delta_neg_reg ? ENTRY_W'(0) - tick_q : tick_q);
                    state_next    = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                win_we        = 1'b1;
                sum_next      = sum_reg + SUM_W'(tick_val_reg) - SUM_W'(old_entry);
                baseline_next = count_reg;
                slot_next     = (slot_reg == SLOT_W'(WINDOW_DEPTH - 1)) ? '0
                                                                         : slot_reg + SLOT_W'(1);
                if (!window_full)
                begin
                    fill_next = fill_reg + FILL_W'(1);
                end
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (fill_reg == '0)
                begin
                    speed_next = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(sum_mag);
                    div_divisor  = DVS_W'(fill_reg);
                    state_next   = ST_AVG_DIV;
                end
            end
            ST_AVG_DIV:
            begin
                if (div_done)
                begin
                    avg_next   = div_quotient[SUM_W-1:0];
                    state_next = ST_MUL_LO;
                end
            end
            ST_MUL_LO:
            begin
                prod_lo_next = mul_p;
                state_next   = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                prod_hi_next = mul_p;
                state_next   = ST_SATURATE;
            end
            ST_SATURATE:
            begin
                speed_next = signed'(speed_neg ? SPEED_W'(0) - q_mag : q_mag);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (cmd.release_lane)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            baseline_reg <= '0;
            slot_reg     <= '0;
            fill_reg     <= '0;
            sum_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            baseline_reg <= baseline_next;
            slot_reg     <= slot_next;
            fill_reg     <= fill_next;
            sum_reg      <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_delta_reg <= raw_delta_next;
        count_reg     <= count_next;
        scale_reg     <= scale_next;
        delta_neg_reg <= delta_neg_next;
        tick_val_reg  <= tick_val_next;
        avg_reg       <= avg_next;
        prod_lo_reg   <= prod_lo_next;
        prod_hi_reg   <= prod_hi_next;
        speed_reg     <= speed_next;
        if (win_we)
        begin
            win_reg[slot_reg] <= tick_val_reg;
        end
    end

    assign status.done      = (state_reg == ST_DONE);
    assign status.speed     = speed_reg;
    assign status.raw_delta = raw_delta_reg;

endmodule

### rtl/dual_encoder_speed_average.sv
// Accept edge to result valid: a restart beat sends the lanes straight to done; a zero-tick
// beat makes one pass through each lane's iterative divider (none with an empty window); a
// measurement beat makes two passes, DIV_STEPS quotient bits a cycle.
// Throughput: one beat in flight; the next sample is taken once the result sits in the
// output register, even while that result still waits to be taken.
// Reset (rst_n, async low): baselines, window fill and slot, sums and counters clear, scales go to 25.0.
module dual_encoder_speed_average (
    input  logic                           clk,
    input  logic                           rst_n,
    desa_sample_if.sink                    sample,
    desa_report_if.source                  report,
    input  logic                           cfg_write,
    input  desa_pkg::cfg_index_t           cfg_index,
    input  logic [desa_pkg::CFG_DATA_W-1:0] cfg_data
);
    import desa_pkg::*;

    localparam logic signed [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1638400);

    // configuration: per-wheel Q16.16 scale
    logic signed [SCALE_W-1:0] left_scale_reg, left_scale_next;
    logic signed [SCALE_W-1:0] right_scale_reg, right_scale_next;

    // sequencing: one beat in the lanes at a time
    logic                      busy_reg, busy_next;
    logic [COUNT_W-1:0]        accepted_total_reg, accepted_total_next;
    logic                      updated_reg, updated_next;

    // output register, parts the lanes from the result channel
    logic                      out_valid_reg, out_valid_next;
    logic                      out_updated_reg, out_updated_next;
    logic signed [SPEED_W-1:0] out_left_speed_reg, out_left_speed_next;
    logic signed [SPEED_W-1:0] out_right_speed_reg, out_right_speed_next;
    logic signed [COUNT_W-1:0] out_left_delta_reg, out_left_delta_next;
    logic signed [COUNT_W-1:0] out_right_delta_reg, out_right_delta_next;
    logic [COUNT_W-1:0]        out_total_reg, out_total_next;

    logic                      accept;
    logic                      measure;
    logic                      load_out;
    lane_cmd_t                 lane_cmd;
    lane_status_t              left_st;
    lane_status_t              right_st;

    assign sample.ready = !busy_reg;
    assign accept       = sample.valid && !busy_reg;
    assign measure      = !sample.restart && (sample.tick_span != '0);

    // merge: both lanes finish together; move the pair into the output slot once free
    assign load_out = busy_reg && left_st.done && right_st.done
                   && (!out_valid_reg || report.ready);

    assign lane_cmd.start        = accept;
    assign lane_cmd.release_lane = load_out;
    assign lane_cmd.restart      = sample.restart;
    assign lane_cmd.tick_span    = sample.tick_span;

    desa_lane u_left_lane (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (lane_cmd),
        .count  (sample.left_hall_count),
        .scale  (left_scale_reg),
        .status (left_st)
    );

    desa_lane u_right_lane (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (lane_cmd),
        .count  (sample.right_hall_count),
        .scale  (right_scale_reg),
        .status (right_st)
    );

    always_comb
    begin
        left_scale_next  = left_scale_reg;
        right_scale_next = right_scale_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_LEFT_SCALE:  left_scale_next  = signed'(cfg_data);
                CFG_RIGHT_SCALE: right_scale_next = signed'(cfg_data);
                default:         left_scale_next  = left_scale_reg;
            endcase
        end
    end

    always_comb
    begin
        busy_next           = busy_reg;
        accepted_total_next = accepted_total_reg;
        updated_next        = updated_reg;
        if (accept)
        begin
            busy_next    = 1'b1;
            updated_next = measure;
            if (measure)
            begin
                accepted_total_next = accepted_total_reg + COUNT_W'(1);
            end
        end
        else if (load_out)
        begin
            busy_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next       = out_valid_reg;
        out_updated_next     = out_updated_reg;
        out_left_speed_next  = out_left_speed_reg;
        out_right_speed_next = out_right_speed_reg;
        out_left_delta_next  = out_left_delta_reg;
        out_right_delta_next = out_right_delta_reg;
        out_total_next       = out_total_reg;
        if (load_out)
        begin
            out_valid_next       = 1'b1;
            out_updated_next     = updated_reg;
            out_left_speed_next  = left_st.speed;
            out_right_speed_next = right_st.speed;
            out_left_delta_next  = left_st.raw_delta;
            out_right_delta_next = right_st.raw_delta;
            out_total_next       = accepted_total_reg;
        end
        else if (report.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_scale_reg     <= SCALE_RESET;
            right_scale_reg    <= SCALE_RESET;
            busy_reg           <= 1'b0;
            accepted_total_reg <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            left_scale_reg     <= left_scale_next;
            right_scale_reg    <= right_scale_next;
            busy_reg           <= busy_next;
            accepted_total_reg <= accepted_total_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // payload: hold with the beat, no reset needed
    always_ff @(posedge clk)
    begin
        updated_reg         <= updated_next;
        out_updated_reg     <= out_updated_next;
        out_left_speed_reg  <= out_left_speed_next;
        out_right_speed_reg <= out_right_speed_next;
        out_left_delta_reg  <= out_left_delta_next;
        out_right_delta_reg <= out_right_delta_next;
        out_total_reg       <= out_total_next;
    end

    assign report.valid           = out_valid_reg;
    assign report.updated         = out_updated_reg;
    assign report.left_speed      = out_left_speed_reg;
    assign report.right_speed     = out_right_speed_reg;
    assign report.left_raw_delta  = out_left_delta_reg;
    assign report.right_raw_delta = out_right_delta_reg;
    assign report.update_total    = out_total_reg;

`ifndef SYNTH
    // lanes run the same sequence, so they must finish on the same cycle
    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        left_st.done == right_st.done)
        else $error("lanes out of step");

    // a new result only appears after a beat was in the lanes
    a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(report.valid) |-> $past(busy_reg))
        else $error("result without an accepted sample");

    // loading the output slot frees the lanes and shows the beat
    a_load_frees_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (!busy_reg && report.valid && !left_st.done))
        else $error("output load did not release the lanes");
`endif

endmodule

### tb/dual_encoder_speed_average_tb.sv
// Self-checking bench for the dual encoder speed averager: a directed stimulus
// table, then randomized phases of measurements under several scale settings.
// Depends on desa_pkg, desa_sample_if, desa_report_if and the block itself.
`timescale 1ns / 100ps

module dual_encoder_speed_average_tb;
    import desa_pkg::*;

    localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
    localparam int PHASE_BEATS   = 150;   // random beats per scale setting
    localparam int PHASE_COUNT   = 6;
    localparam int DRAIN_CYCLES  = 80;    // settle time after the last expected report

    // one sample beat as driven on the measurement channel
    typedef struct packed {
        logic                      restart;
        logic signed [COUNT_W-1:0] left_hall;
        logic signed [COUNT_W-1:0] right_hall;
        logic [TICK_W-1:0]         tick_span;
    } measurement_t;

    // one report beat as seen on the result channel
    typedef struct packed {
        logic                      updated;
        logic signed [SPEED_W-1:0] left_speed;
        logic signed [SPEED_W-1:0] right_speed;
        logic signed [COUNT_W-1:0] left_raw_delta;
        logic signed [COUNT_W-1:0] right_raw_delta;
        logic [COUNT_W-1:0]        update_total;
    } speed_report_t;

    typedef enum logic {
        ROW_BEAT,
        ROW_CONFIG
    } plan_kind_t;

    // one row of the directed plan: either a sample beat or a scale write;
    // typed rows carry the report expected, the rest go through the predictor
    typedef struct packed {
        plan_kind_t           kind;
        measurement_t         beat;
        cfg_index_t           cfg_reg;
        logic [SCALE_W-1:0]   cfg_value;
        logic                 typed;
        speed_report_t        want;
    } plan_row_t;

    localparam measurement_t  NO_BEAT   = '0;
    localparam speed_report_t NO_REPORT = '0;

    localparam int PLAN_ROWS = 25;
    localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
        // fresh after reset: nothing stored, nothing measured
        '{ROW_BEAT, '{1'b0, 32'sd0, 32'sd0, 8'd0}, CFG_LEFT_SCALE, 32'h0, 1'b1,
          '{1'b0, 48'sd0, 48'sd0, 32'sd0, 32'sd0, 32'd0}},
        // zero tick span: deltas show, window stays empty
        '{ROW_BEAT, '{1'b0, 32'sd5, -32'sd3, 8'd0}, CFG_LEFT_SCALE, 32'h0, 1'b1,
          '{1'b0, 48'sd0, 48'sd0, 32'sd5, -32'sd3, 32'd0}},
        // first measurement at unit span, scale 25.0
        '{ROW_BEAT, '{1'b0, 32'sd100, -32'sd100, 8'd1}, CFG_LEFT_SCALE, 32'h0, 1'b1,
          '{1'b1, 48'sd163840000, -48'sd163840000, 32'sd100, -32'sd100, 32'd1}},
        // restart at the count extremes: all zero, total kept
        '{ROW_BEAT, '{1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 8'd37}, CFG_LEFT_SCALE, 32'h0,
          1'b1, '{1'b0, 48'sd0, 48'sd0, 32'sd0, 32'sd0, 32'd1}},
        // counts wrap across the sign boundary, largest span
        '{ROW_BEAT, '{1'b0, 32'sh8000_0000, 32'sh7FFF_FFFF, 8'd255}, CFG_LEFT_SCALE, 32'h0,
          1'b0, NO_REPORT},
        // largest deltas in both directions at unit span: both speeds saturate
        '{ROW_BEAT, '{1'b0, 32'sh0000_0000, 32'shFFFF_FFFE, 8'd1}, CFG_LEFT_SCALE, 32'h0,
          1'b0, NO_REPORT},
        '{ROW_BEAT, '{1'b0, 32'sh0000_0001, 32'shFFFF_FFFF, 8'd0}, CFG_LEFT_SCALE, 32'h0,
          1'b0, NO_REPORT},
        // most negative and most positive scales
        '{ROW_CONFIG, NO_BEAT, CFG_LEFT_SCALE, 32'h8000_0000, 1'b0, NO_REPORT},
        '{ROW_CONFIG, NO_BEAT, CFG_RIGHT_SCALE, 32'h7FFF_FFFF, 1'b0, NO_REPORT},
        '{ROW_BEAT, '{1'b0, 32'sh0000_0001, 32'shFFFF_FFFF, 8'd0}, CFG_LEFT_SCALE, 32'h0,
          1'b0, NO_REPORT},
        '{ROW_BEAT, '{1'b0, 32'sh1234_5678, 32'shEDCB_A987, 8'd200}, CFG_LEFT_SCALE, 32'h0,
          1'b0, NO_REPORT},
        // restart with zero span: window clears, total of four kept
        '{ROW_BEAT, '{1'b1, 32'shFFFF_FFFF, 32'sh0000_0000, 8'd0}, CFG_LEFT_SCALE, 32'h0,
          1'b1, '{1'b0, 48'sd0, 48'sd0, 32'sd0, 32'sd0, 32'd4}},
        // ten small measurements: odd spans truncate negative rates toward
        // zero, and the ring wraps past its depth
        '{ROW_BEAT, '{1'b0, 32'sd9, -32'sd7, 8'd3}, CFG_LEFT_SCALE, 32'h0, 1'b0, NO_REPORT},
        '{ROW_BEAT, '{1'b0, 32'sd20, -32'sd20, 8'd7}, CFG_LEFT_SCALE, 32'h0, 1'b0, NO_REPORT},
        '{ROW_BEAT, '{1'b0, 32'sd13, -32'sd9, 8'd3}, CFG_LEFT_SCALE, 32'h0, 1'b0, NO_REPORT},
        '{ROW_BEAT, '{1'b0, 32'sd1000, 32'sd1000, 8'd255}, CFG_LEFT_SCALE, 32'h0, 1'b0,
          NO_REPORT},
        '{ROW_BEAT, '{1'b0, -32'sd50000, 32'sd50000, 8'd128}, CFG_LEFT_SCALE, 32'h0, 1'b0,
          NO_REPORT},
        '{ROW_BEAT, '{1'b0, -32'sd49990, 32'sd49980, 8'd1}, CFG_LEFT_SCALE, 32'h0, 1'b0,
          NO_REPORT},
        '{ROW_BEAT, '{1'b0, 32'sd0, 32'sd0, 8'd9}, CFG_LEFT_SCALE, 32'h0, 1'b0, NO_REPORT},
        '{ROW_BEAT, '{1'b0, 32'sd7, -32'sd7, 8'd2}, CFG_LEFT_SCALE, 32'h0, 1'b0, NO_REPORT},
        '{ROW_BEAT, '{1'b0, 32'sd8, -32'sd8, 8'd1}, CFG_LEFT_SCALE, 32'h0, 1'b0, NO_REPORT},
        '{ROW_BEAT, '{1'b0, 32'sd300, -32'sd300, 8'd11}, CFG_LEFT_SCALE, 32'h0, 1'b0,
          NO_REPORT},
        // zero scale on the left, minus one on the right
        '{ROW_CONFIG, NO_BEAT, CFG_LEFT_SCALE, 32'h0000_0000, 1'b0, NO_REPORT},
        '{ROW_CONFIG, NO_BEAT, CFG_RIGHT_SCALE, 32'hFFFF_0000, 1'b0, NO_REPORT},
        '{ROW_BEAT, '{1'b0, 32'sd301, -32'sd301, 8'd0}, CFG_LEFT_SCALE, 32'h0, 1'b0,
          NO_REPORT}
    };

    // scale settings of the random phases; phases three and four draw theirs
    localparam logic [SCALE_W-1:0] PHASE_LEFT [PHASE_COUNT] = '{
        32'h7FFF_FFFF, 32'd1638400, 32'h0001_0000, 32'h0, 32'h0, 32'h0000_0000
    };
    localparam logic [SCALE_W-1:0] PHASE_RIGHT [PHASE_COUNT] = '{
        32'h8000_0000, 32'd1638400, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0000_0001
    };

    logic clk;
    logic rst_n;
    logic cfg_write;
    cfg_index_t cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    desa_sample_if sample_ch ();
    desa_report_if report_ch ();

    dual_encoder_speed_average i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .report    (report_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ---------------------------------------------------------------
    // Speed predictor state: a shadow of the block's baselines, ring
    // window, running sums and scales. Reset is applied only once, so
    // the declaration values stand for the reset state.
    // ---------------------------------------------------------------
    logic signed [SCALE_W-1:0] left_gain  = 32'sd1638400;
    logic signed [SCALE_W-1:0] right_gain = 32'sd1638400;
    logic [COUNT_W-1:0] left_base  = '0;
    logic [COUNT_W-1:0] right_base = '0;
    longint left_taps  [WINDOW_DEPTH] = '{default: 0};
    longint right_taps [WINDOW_DEPTH] = '{default: 0};
    longint left_tap_sum  = 0;
    longint right_tap_sum = 0;
    int tap_slot    = 0;
    int taps_filled = 0;
    logic [COUNT_W-1:0] measured_total = '0;

    speed_report_t expected_reports [$];
    int  failures      = 0;
    int  results_taken = 0;
    bit  calm          = 1'b0;    // no idling on either side while set

    speed_report_t seen_report;
    speed_report_t oldest_report;

    // Signed per-tick rate with FRACTION_BITS fraction bits, truncated toward zero.
    function automatic longint rate_per_tick(logic [COUNT_W-1:0] delta_bits,
                                             logic [TICK_W-1:0] ticks);
        longint delta;
        longint mag;
        longint q;
        delta = longint'($signed(delta_bits));
        mag   = (delta < 0) ? -delta : delta;
        q     = (mag << FRACTION_BITS) / int'(ticks);
        return (delta < 0) ? -q : q;
    endfunction

    // Window average times a Q16.16 gain, truncated toward zero and clamped to 48 bits.
    function automatic logic signed [SPEED_W-1:0] scaled_speed(longint tap_sum,
                                                               logic signed [SCALE_W-1:0] gain);
        longint       avg;
        longint       gain_mag;
        logic [127:0] avg_wide;
        logic [127:0] gain_wide;
        logic [127:0] q;
        logic [127:0] lim;
        logic [SPEED_W-1:0] mag;
        bit           neg;
        if (taps_filled == 0)
            return '0;
        neg       = (tap_sum < 0) != (gain < 0);
        avg       = ((tap_sum < 0) ? -tap_sum : tap_sum) / taps_filled;
        gain_mag  = longint'(gain);
        gain_mag  = (gain_mag < 0) ? -gain_mag : gain_mag;
        avg_wide  = 128'(avg);
        gain_wide = 128'(gain_mag);
        q         = (avg_wide * gain_wide) >> SCALE_FRAC;
        lim       = neg ? (128'd1 << (SPEED_W - 1)) : (128'd1 << (SPEED_W - 1)) - 1;
        if (q > lim)
            q = lim;
        mag = q[SPEED_W-1:0];
        return neg ? -mag : mag;
    endfunction

    // Advance the shadow state by one sample beat and return the report it causes.
    function automatic speed_report_t predict_report(measurement_t m);
        speed_report_t r;
        logic [COUNT_W-1:0] ld;
        logic [COUNT_W-1:0] rd;
        longint lv;
        longint rv;
        ld = m.left_hall - left_base;
        rd = m.right_hall - right_base;
        r.updated = 1'b0;
        if (m.restart)
        begin
            // capture the counts, empty the window; the total survives
            left_base  = m.left_hall;
            right_base = m.right_hall;
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                left_taps[i]  = 0;
                right_taps[i] = 0;
            end
            left_tap_sum  = 0;
            right_tap_sum = 0;
            tap_slot      = 0;
            taps_filled   = 0;
            ld = '0;
            rd = '0;
        end
        else if (m.tick_span != 0)
        begin
            lv = rate_per_tick(ld, m.tick_span);
            rv = rate_per_tick(rd, m.tick_span);
            left_base  = m.left_hall;
            right_base = m.right_hall;
            left_tap_sum  += lv - left_taps[tap_slot];
            right_tap_sum += rv - right_taps[tap_slot];
            left_taps[tap_slot]  = lv;
            right_taps[tap_slot] = rv;
            tap_slot = (tap_slot + 1) % WINDOW_DEPTH;
            if (taps_filled < WINDOW_DEPTH)
                taps_filled++;
            measured_total++;
            r.updated = 1'b1;
        end
        r.left_speed      = scaled_speed(left_tap_sum, left_gain);
        r.right_speed     = scaled_speed(right_tap_sum, right_gain);
        r.left_raw_delta  = ld;
        r.right_raw_delta = rd;
        r.update_total    = measured_total;
        return r;
    endfunction

    // Roll the dice for an idle cycle on either side of the block.
    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 29);
    endfunction

    // Offer one sample beat: idle at random, hold it until taken, then queue the
    // report that it is due to produce. Enter and leave at a falling edge.
    task automatic offer_beat(measurement_t m, bit typed, speed_report_t want);
        speed_report_t predicted;
        while (take_break())
        begin
            sample_ch.valid = 1'b0;
            @(negedge clk);
        end
        sample_ch.restart          = m.restart;
        sample_ch.left_hall_count  = m.left_hall;
        sample_ch.right_hall_count = m.right_hall;
        sample_ch.tick_span        = m.tick_span;
        sample_ch.valid            = 1'b1;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        predicted = predict_report(m);
        expected_reports.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // Write one scale once the block has handed over every pending report.
    task automatic write_scale(cfg_index_t idx, logic [SCALE_W-1:0] value);
        sample_ch.valid = 1'b0;
        while (expected_reports.size() != 0)
            @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_write = 1'b0;
        if (idx == CFG_LEFT_SCALE)
            left_gain = value;
        else
            right_gain = value;
    endtask

    // Compare one report field; X on the block side counts as a mismatch.
    task automatic check_field(string field, logic signed [63:0] want,
                               logic signed [63:0] got);
        if (got !== want)
        begin
            failures++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop for a hung handshake.
    initial
    begin
        #5_000_000;
        $display("dual_encoder_speed_average_tb: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // Receiver: drop ready at random, and twice hold it low for a long
    // stretch so that the block fills up and stalls the sample channel.
    // ---------------------------------------------------------------
    initial
    begin
        int next_hold;
        next_hold = 25;
        report_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (results_taken >= next_hold)
            begin
                report_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                next_hold = (next_hold == 25) ? 600 : 32'h7FFF_FFFF;
            end
            report_ch.ready = !take_break();
        end
    end

    // Check every report beat against the oldest expectation.
    always @(posedge clk)
    begin
        if (report_ch.valid && report_ch.ready)
        begin
            results_taken++;
            seen_report.updated         = report_ch.updated;
            seen_report.left_speed      = report_ch.left_speed;
            seen_report.right_speed     = report_ch.right_speed;
            seen_report.left_raw_delta  = report_ch.left_raw_delta;
            seen_report.right_raw_delta = report_ch.right_raw_delta;
            seen_report.update_total    = report_ch.update_total;
            if (expected_reports.size() == 0)
            begin
                failures++;
                $display("%0t: report expected none, got update_total %0d",
                         $time, seen_report.update_total);
            end
            else
            begin
                oldest_report = expected_reports.pop_front();
                check_field("updated", oldest_report.updated, seen_report.updated);
                check_field("left_speed", oldest_report.left_speed,
                            seen_report.left_speed);
                check_field("right_speed", oldest_report.right_speed,
                            seen_report.right_speed);
                check_field("left_raw_delta", oldest_report.left_raw_delta,
                            seen_report.left_raw_delta);
                check_field("right_raw_delta", oldest_report.right_raw_delta,
                            seen_report.right_raw_delta);
                check_field("update_total", oldest_report.update_total,
                            seen_report.update_total);
            end
        end
    end

    // ---------------------------------------------------------------
    // Sender and run control: directed table, then random phases.
    // ---------------------------------------------------------------
    initial
    begin
        measurement_t       m;
        logic [COUNT_W-1:0] left_pos;
        logic [COUNT_W-1:0] right_pos;
        logic [SCALE_W-1:0] lg;
        logic [SCALE_W-1:0] rg;
        int                 pick;

        // hold every input at a known value through reset
        rst_n                      = 1'b0;
        cfg_write                  = 1'b0;
        cfg_index                  = CFG_LEFT_SCALE;
        cfg_data                   = '0;
        sample_ch.valid            = 1'b0;
        sample_ch.restart          = 1'b0;
        sample_ch.left_hall_count  = '0;
        sample_ch.right_hall_count = '0;
        sample_ch.tick_span        = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // walk the directed table; scale writes wait for the block to drain
        for (int row = 0; row < PLAN_ROWS; row++)
        begin
            if (DIRECTED_PLAN[row].kind == ROW_CONFIG)
                write_scale(DIRECTED_PLAN[row].cfg_reg, DIRECTED_PLAN[row].cfg_value);
            else
                offer_beat(DIRECTED_PLAN[row].beat, DIRECTED_PLAN[row].typed,
                           DIRECTED_PLAN[row].want);
        end

        // random phases: mostly steady wheel motion at small spans, with
        // restarts, skipped ticks and wild count jumps mixed in
        left_pos  = 32'sd301;
        right_pos = -32'sd301;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase == 3 || phase == 4)
            begin
                lg = $urandom;
                rg = $urandom;
            end
            else
            begin
                lg = PHASE_LEFT[phase];
                rg = PHASE_RIGHT[phase];
            end
            write_scale(CFG_LEFT_SCALE, lg);
            write_scale(CFG_RIGHT_SCALE, rg);
            calm = (phase == 1);
            repeat (PHASE_BEATS)
            begin
                pick      = $urandom_range(99);
                m.restart = 1'b0;
                if (pick < 3)
                begin
                    m.restart   = 1'b1;
                    left_pos    = $urandom;
                    right_pos   = $urandom;
                    m.tick_span = TICK_W'($urandom_range(255));
                end
                else if (pick < 8)
                begin
                    left_pos    = $urandom;
                    right_pos   = $urandom;
                    m.tick_span = TICK_W'($urandom_range(255));
                end
                else
                begin
                    if ($urandom_range(11) == 0)
                        m.tick_span = '0;
                    else if ($urandom_range(9) == 0)
                        m.tick_span = TICK_W'($urandom_range(255, 1));
                    else
                        m.tick_span = TICK_W'($urandom_range(12, 1));
                    left_pos  = left_pos + (int'($urandom_range(8000)) - 4000);
                    right_pos = right_pos + (int'($urandom_range(8000)) - 4000);
                end
                m.left_hall  = left_pos;
                m.right_hall = right_pos;
                offer_beat(m, 1'b0, NO_REPORT);
            end
        end
        sample_ch.valid = 1'b0;
        calm = 1'b0;

        // drain, then give a straggler time to show up
        while (expected_reports.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (failures == 0)
            $display("dual_encoder_speed_average_tb: PASS");
        else
            $display("dual_encoder_speed_average_tb: FAIL");
        $finish;
    end

endmodule
